// File: sv/rrbr_pkg.sv
// Package for the round-robin backoff retry picker: widths, reset values,
// register indexes, shared types and the cursor wrap function.
// No dependencies.
package rrbr_pkg;

    localparam int NODE_COUNT    = 6;
    localparam int COUNT_BITS    = 16;
    localparam int NODE_BITS     = $clog2(NODE_COUNT);
    localparam int TIME_BITS     = 64;
    localparam int SPACING_BITS  = 27;
    localparam int BASE_BITS     = 20;
    localparam int MAXI_BITS     = 27;
    localparam int MASK_BITS     = 6;
    localparam int SEL_BITS      = 3;
    localparam int SHIFT_LIMIT   = 28;
    localparam int SHIFT_BITS    = $clog2(SHIFT_LIMIT);
    localparam int IV_BITS       = BASE_BITS + SHIFT_LIMIT - 1;

    localparam int CFG_ADDR_BITS = 2;
    localparam int CFG_DATA_BITS = 27;

    localparam int IN_FIELD_BITS = TIME_BITS + 3 * MASK_BITS;
    localparam int IN_DATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS = ((SEL_BITS + 7) / 8) * 8;
    localparam int MISS_LSB      = TIME_BITS;
    localparam int BLK_LSB       = MISS_LSB + MASK_BITS;
    localparam int PRES_LSB      = BLK_LSB + MASK_BITS;

    localparam logic [SPACING_BITS-1:0] RST_MIN_SPACING  = SPACING_BITS'(100000);
    localparam logic [BASE_BITS-1:0]    RST_BASE_INTERVAL = BASE_BITS'(100000);
    localparam logic [MAXI_BITS-1:0]    RST_MAX_INTERVAL  = MAXI_BITS'(5000000);

    typedef logic [CFG_ADDR_BITS-1:0] cfg_addr_t;

    localparam cfg_addr_t REG_MIN_SPACING   = cfg_addr_t'(0);
    localparam cfg_addr_t REG_BASE_INTERVAL = cfg_addr_t'(1);
    localparam cfg_addr_t REG_MAX_INTERVAL  = cfg_addr_t'(2);

    typedef struct packed {
        logic [SPACING_BITS-1:0] min_spacing;
        logic [BASE_BITS-1:0]    base_interval;
        logic [MAXI_BITS-1:0]    max_interval;
    } cfg_t;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef struct packed {
        alu_op_t              op;
        logic [TIME_BITS-1:0] a;
        logic [TIME_BITS-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic [TIME_BITS-1:0] sum;
        logic                 carry;
    } alu_rsp_t;

    typedef struct packed {
        logic                  en;
        logic [NODE_BITS-1:0]  idx;
        logic [TIME_BITS-1:0]  due;
        logic [COUNT_BITS-1:0] count;
    } node_wr_t;

    typedef struct packed {
        logic [TIME_BITS-1:0]  due;
        logic [COUNT_BITS-1:0] count;
    } node_rd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GAP_DIFF,
        ST_GAP_CMP,
        ST_SCAN,
        ST_BUMP,
        ST_SHIFT,
        ST_CAP,
        ST_COMMIT,
        ST_OBSERVE,
        ST_DONE
    } state_t;

    function automatic logic [NODE_BITS-1:0] next_node(input logic [NODE_BITS-1:0] n);
        logic [NODE_BITS-1:0] r;
        if (n == NODE_BITS'(NODE_COUNT - 1))
        begin
            r = '0;
        end
        else
        begin
            r = n + NODE_BITS'(1);
        end
        return r;
    endfunction

endpackage

// File: sv/rrbr_alu.sv
// Shared 64-bit add/subtract unit with carry out; carry on subtract means a >= b.
// Depends on rrbr_pkg.
module rrbr_alu (
    input  rrbr_pkg::alu_req_t req,
    output rrbr_pkg::alu_rsp_t rsp
);

    logic [rrbr_pkg::TIME_BITS-1:0] b_eff;
    logic [rrbr_pkg::TIME_BITS:0]   full;

    always_comb
    begin
        b_eff = (req.op == rrbr_pkg::ALU_SUB) ? ~req.b : req.b;
        full  = {1'b0, req.a} + {1'b0, b_eff}
              + (rrbr_pkg::TIME_BITS + 1)'(req.op == rrbr_pkg::ALU_SUB);
        rsp.sum   = full[rrbr_pkg::TIME_BITS-1:0];
        rsp.carry = full[rrbr_pkg::TIME_BITS];
    end

endmodule

// File: sv/rrbr_node_store.sv
// Per-node due times and retry counts: one read port, one write port,
// and a parallel clear by presence mask. Depends on rrbr_pkg.
module rrbr_node_store (
    input  logic                             clk,
    input  logic                             rst_n,
    input  rrbr_pkg::node_wr_t               wr,
    input  logic [rrbr_pkg::NODE_COUNT-1:0]  clear,
    input  logic [rrbr_pkg::NODE_BITS-1:0]   rd_idx,
    output rrbr_pkg::node_rd_t               rd
);

    logic [rrbr_pkg::TIME_BITS-1:0]  due_reg   [rrbr_pkg::NODE_COUNT];
    logic [rrbr_pkg::COUNT_BITS-1:0] count_reg [rrbr_pkg::NODE_COUNT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < rrbr_pkg::NODE_COUNT; i++)
            begin
                due_reg[i]   <= '0;
                count_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < rrbr_pkg::NODE_COUNT; i++)
            begin
                if (clear[i])
                begin
                    due_reg[i]   <= '0;
                    count_reg[i] <= '0;
                end
                else if (wr.en && (wr.idx == rrbr_pkg::NODE_BITS'(i)))
                begin
                    due_reg[i]   <= wr.due;
                    count_reg[i] <= wr.count;
                end
            end
        end
    end

    always_comb
    begin
        rd.due   = due_reg[rd_idx];
        rd.count = count_reg[rd_idx];
    end

endmodule

// File: sv/rrbr_ctrl.sv
// Sequencer: input capture, spacing gate, round-robin scan, backoff update
// and output register. Drives the shared ALU and the node store. Depends on rrbr_pkg.
module rrbr_ctrl (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [rrbr_pkg::IN_DATA_BITS-1:0]   s_tdata,
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [rrbr_pkg::OUT_DATA_BITS-1:0]  m_tdata,
    input  rrbr_pkg::cfg_t                      cfg,
    output rrbr_pkg::alu_req_t                  alu_req,
    input  rrbr_pkg::alu_rsp_t                  alu_rsp,
    output rrbr_pkg::node_wr_t                  node_wr,
    output logic [rrbr_pkg::NODE_COUNT-1:0]     node_clear,
    output logic [rrbr_pkg::NODE_BITS-1:0]      rd_idx,
    input  rrbr_pkg::node_rd_t                  node_rd
);

    rrbr_pkg::state_t                 state_reg,   state_next;
    logic [rrbr_pkg::TIME_BITS-1:0]   now_reg,     now_next;
    logic [rrbr_pkg::NODE_COUNT-1:0]  need_reg,    need_next;
    logic [rrbr_pkg::NODE_COUNT-1:0]  pres_reg,    pres_next;
    logic [rrbr_pkg::NODE_BITS-1:0]   idx_reg,     idx_next;
    logic [rrbr_pkg::NODE_BITS-1:0]   step_reg,    step_next;
    logic [rrbr_pkg::TIME_BITS-1:0]   diff_reg,    diff_next;
    logic [rrbr_pkg::COUNT_BITS-1:0]  cnt_reg,     cnt_next;
    logic [rrbr_pkg::IV_BITS-1:0]     iv_reg,      iv_next;
    logic [rrbr_pkg::SEL_BITS-1:0]    res_reg,     res_next;
    logic                             attempt_reg, attempt_next;
    logic [rrbr_pkg::TIME_BITS-1:0]   last_reg,    last_next;
    logic [rrbr_pkg::NODE_BITS-1:0]   cursor_reg,  cursor_next;
    logic                             out_valid_reg, out_valid_next;
    logic [rrbr_pkg::SEL_BITS-1:0]    out_data_reg,  out_data_next;
    logic [rrbr_pkg::COUNT_BITS-1:0]  cnt_less2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rrbr_pkg::ST_IDLE;
            attempt_reg   <= 1'b0;
            last_reg      <= '0;
            cursor_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            attempt_reg   <= attempt_next;
            last_reg      <= last_next;
            cursor_reg    <= cursor_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg      <= now_next;
        need_reg     <= need_next;
        pres_reg     <= pres_next;
        idx_reg      <= idx_next;
        step_reg     <= step_next;
        diff_reg     <= diff_next;
        cnt_reg      <= cnt_next;
        iv_reg       <= iv_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        now_next       = now_reg;
        need_next      = need_reg;
        pres_next      = pres_reg;
        idx_next       = idx_reg;
        step_next      = step_reg;
        diff_next      = diff_reg;
        cnt_next       = cnt_reg;
        iv_next        = iv_reg;
        res_next       = res_reg;
        attempt_next   = attempt_reg;
        last_next      = last_reg;
        cursor_next    = cursor_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        alu_req.op     = rrbr_pkg::ALU_SUB;
        alu_req.a      = now_reg;
        alu_req.b      = '0;
        node_wr        = '0;
        node_clear     = '0;
        s_tready       = (state_reg == rrbr_pkg::ST_IDLE);
        cnt_less2      = cnt_reg - rrbr_pkg::COUNT_BITS'(2);

        unique case (state_reg)
            rrbr_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    now_next = s_tdata[rrbr_pkg::TIME_BITS-1:0];
                    for (int i = 0; i < rrbr_pkg::NODE_COUNT; i++)
                    begin
                        if (i < rrbr_pkg::MASK_BITS)
                        begin
                            need_next[i] = s_tdata[rrbr_pkg::MISS_LSB + i]
                                         | s_tdata[rrbr_pkg::BLK_LSB + i];
                            pres_next[i] = s_tdata[rrbr_pkg::PRES_LSB + i];
                        end
                        else
                        begin
                            need_next[i] = 1'b0;
                            pres_next[i] = 1'b0;
                        end
                    end
                    state_next = s_tuser ? rrbr_pkg::ST_OBSERVE : rrbr_pkg::ST_GAP_DIFF;
                end
            end
            rrbr_pkg::ST_GAP_DIFF:
            begin
                alu_req.b  = last_reg;
                diff_next  = alu_rsp.sum;
                state_next = rrbr_pkg::ST_GAP_CMP;
            end
            rrbr_pkg::ST_GAP_CMP:
            begin
                alu_req.a = diff_reg;
                alu_req.b = rrbr_pkg::TIME_BITS'(cfg.min_spacing);
                if (attempt_reg && !alu_rsp.carry)
                begin
                    res_next   = '0;
                    state_next = rrbr_pkg::ST_DONE;
                end
                else
                begin
                    idx_next   = cursor_reg;
                    step_next  = '0;
                    state_next = rrbr_pkg::ST_SCAN;
                end
            end
            rrbr_pkg::ST_SCAN:
            begin
                alu_req.b = node_rd.due;
                if (need_reg[idx_reg] && alu_rsp.carry)
                begin
                    state_next = rrbr_pkg::ST_BUMP;
                end
                else if (step_reg == rrbr_pkg::NODE_BITS'(rrbr_pkg::NODE_COUNT - 1))
                begin
                    res_next   = '0;
                    state_next = rrbr_pkg::ST_DONE;
                end
                else
                begin
                    idx_next  = rrbr_pkg::next_node(idx_reg);
                    step_next = step_reg + rrbr_pkg::NODE_BITS'(1);
                end
            end
            rrbr_pkg::ST_BUMP:
            begin
                cnt_next   = (&node_rd.count) ? node_rd.count
                                              : node_rd.count + rrbr_pkg::COUNT_BITS'(1);
                state_next = rrbr_pkg::ST_SHIFT;
            end
            rrbr_pkg::ST_SHIFT:
            begin
                if (cnt_reg <= rrbr_pkg::COUNT_BITS'(2))
                begin
                    iv_next = rrbr_pkg::IV_BITS'(cfg.base_interval);
                end
                else if (cfg.base_interval == '0)
                begin
                    iv_next = '0;
                end
                else if (cnt_less2 >= rrbr_pkg::COUNT_BITS'(rrbr_pkg::SHIFT_LIMIT))
                begin
                    iv_next = rrbr_pkg::IV_BITS'(cfg.max_interval);
                end
                else
                begin
                    iv_next = rrbr_pkg::IV_BITS'(cfg.base_interval)
                           << cnt_less2[rrbr_pkg::SHIFT_BITS-1:0];
                end
                state_next = rrbr_pkg::ST_CAP;
            end
            rrbr_pkg::ST_CAP:
            begin
                alu_req.a = rrbr_pkg::TIME_BITS'(iv_reg);
                alu_req.b = rrbr_pkg::TIME_BITS'(cfg.max_interval);
                if (alu_rsp.carry)
                begin
                    iv_next = rrbr_pkg::IV_BITS'(cfg.max_interval);
                end
                state_next = rrbr_pkg::ST_COMMIT;
            end
            rrbr_pkg::ST_COMMIT:
            begin
                alu_req.op    = rrbr_pkg::ALU_ADD;
                alu_req.b     = rrbr_pkg::TIME_BITS'(iv_reg);
                node_wr.en    = 1'b1;
                node_wr.idx   = idx_reg;
                node_wr.due   = alu_rsp.sum;
                node_wr.count = cnt_reg;
                last_next     = now_reg;
                attempt_next  = 1'b1;
                cursor_next   = rrbr_pkg::next_node(idx_reg);
                res_next      = rrbr_pkg::SEL_BITS'(idx_reg) + rrbr_pkg::SEL_BITS'(1);
                state_next    = rrbr_pkg::ST_DONE;
            end
            rrbr_pkg::ST_OBSERVE:
            begin
                node_clear = pres_reg;
                res_next   = '0;
                state_next = rrbr_pkg::ST_DONE;
            end
            rrbr_pkg::ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = rrbr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rrbr_pkg::ST_IDLE;
            end
        endcase
    end

    assign rd_idx   = idx_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = rrbr_pkg::OUT_DATA_BITS'(out_data_reg);

endmodule

// File: sv/round_robin_backoff_retry_picker_core.sv
// Top level of the round-robin backoff retry picker: configuration registers
// and the sequencer, shared ALU and node store. Depends on rrbr_pkg and all rrbr_* modules.
//
// Takes one item at a time and returns one result per item. An observe item goes
// straight to its result; a select item is held off by the spacing gate, picks a
// node after a scan of one to six nodes, or ends the scan with no node eligible.
// The single 64-bit adder/subtractor serves the spacing check, the due-time compare
// of one node per cycle, the interval cap and the new due-time sum in turn. A
// finished result waits in an output register; the next item is taken while it
// waits.
module round_robin_backoff_retry_picker_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [rrbr_pkg::IN_DATA_BITS-1:0]    s_tdata,   // now_us, missing_mask, blocked_mask, presence_mask
    input  logic                                 s_tuser,   // mode
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [rrbr_pkg::OUT_DATA_BITS-1:0]   m_tdata,   // selected_node
    input  logic                                 cfg_we,
    input  logic [rrbr_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
    input  logic [rrbr_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    rrbr_pkg::cfg_t                   cfg_reg, cfg_next;
    rrbr_pkg::alu_req_t               alu_req;
    rrbr_pkg::alu_rsp_t               alu_rsp;
    rrbr_pkg::node_wr_t               node_wr;
    rrbr_pkg::node_rd_t               node_rd;
    logic [rrbr_pkg::NODE_COUNT-1:0]  node_clear;
    logic [rrbr_pkg::NODE_BITS-1:0]   rd_idx;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_spacing   <= rrbr_pkg::RST_MIN_SPACING;
            cfg_reg.base_interval <= rrbr_pkg::RST_BASE_INTERVAL;
            cfg_reg.max_interval  <= rrbr_pkg::RST_MAX_INTERVAL;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_addr)
                rrbr_pkg::REG_MIN_SPACING:
                    cfg_next.min_spacing = cfg_data[rrbr_pkg::SPACING_BITS-1:0];
                rrbr_pkg::REG_BASE_INTERVAL:
                    cfg_next.base_interval = cfg_data[rrbr_pkg::BASE_BITS-1:0];
                rrbr_pkg::REG_MAX_INTERVAL:
                    cfg_next.max_interval = cfg_data[rrbr_pkg::MAXI_BITS-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    rrbr_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    rrbr_node_store u_store (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (node_wr),
        .clear  (node_clear),
        .rd_idx (rd_idx),
        .rd     (node_rd)
    );

    rrbr_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg        (cfg_reg),
        .alu_req    (alu_req),
        .alu_rsp    (alu_rsp),
        .node_wr    (node_wr),
        .node_clear (node_clear),
        .rd_idx     (rd_idx),
        .node_rd    (node_rd)
    );

endmodule

// File: sv/rrbr_checker.sv
// Port-level checks for the retry picker top level, bound to it below.
// Depends on rrbr_pkg.
module rrbr_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [rrbr_pkg::OUT_DATA_BITS-1:0]  m_tdata
);

    // one item at a time: busy right after a transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while an item is in flight");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata <= rrbr_pkg::OUT_DATA_BITS'(rrbr_pkg::NODE_COUNT)))
        else $error("selected node out of range");

    // a new result frees the sequencer at the same time
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> s_tready)
        else $error("result shown while the sequencer is still busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result dropped or changed");

endmodule

bind round_robin_backoff_retry_picker_core rrbr_checker u_rrbr_checker (.*);
